// ===== hdl/ppd_pkg.sv =====
`default_nettype none

package ppd_pkg;

   // field widths
   localparam int READING_W = 11;
   localparam int THR_W     = 11;
   localparam int SMP_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_THR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER_SMP = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_SMP  = 2'd3;

   // register reset values
   localparam logic [THR_W-1:0] ENTER_THR_RST = 11'd0;
   localparam logic [THR_W-1:0] EXIT_THR_RST  = 11'd0;
   localparam logic [SMP_W-1:0] ENTER_SMP_RST = 8'd1;
   localparam logic [SMP_W-1:0] EXIT_SMP_RST  = 8'd1;

   typedef enum logic [1:0] {
      TR_NONE       = 2'd0,
      TR_APPROACHED = 2'd1,
      TR_DEPARTED   = 2'd2
   } tr_type;

   typedef struct packed {
      logic [THR_W-1:0] enter_thr;
      logic [THR_W-1:0] exit_thr;
      logic [SMP_W-1:0] enter_smp;
      logic [SMP_W-1:0] exit_smp;
   } cfg_type;

   typedef struct packed {
      tr_type tr;
      logic   near;
   } res_type;

endpackage

`default_nettype wire

// ===== hdl/ppd_filter.sv =====
`default_nettype none

module ppd_filter #(
   parameter int RUN_MAX = 255
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire logic [ppd_pkg::READING_W-1:0]   reading,
   input  wire ppd_pkg::cfg_type                cfg,
   output ppd_pkg::res_type                     res
);
   import ppd_pkg::*;

   localparam int RUN_W = $clog2(RUN_MAX + 1);
   localparam int CMP_W = (RUN_W > SMP_W) ? RUN_W : SMP_W;

   logic             near_flag_ff, near_flag_in;
   logic [RUN_W-1:0] enter_run_ff, enter_run_in;
   logic [RUN_W-1:0] exit_run_ff, exit_run_in;

   logic [RUN_W-1:0] enter_inc, exit_inc;
   logic [SMP_W-1:0] enter_smp_eff, exit_smp_eff;
   logic [THR_W-1:0] exit_thr_eff;
   logic             enter_hit, exit_hit;
   tr_type           tr;

   // saturating run increments
   assign enter_inc = (enter_run_ff < RUN_W'(RUN_MAX)) ? enter_run_ff + RUN_W'(1) : enter_run_ff;
   assign exit_inc  = (exit_run_ff < RUN_W'(RUN_MAX)) ? exit_run_ff + RUN_W'(1) : exit_run_ff;

   // zero sample count acts as one
   assign enter_smp_eff = (cfg.enter_smp == '0) ? SMP_W'(1) : cfg.enter_smp;
   assign exit_smp_eff  = (cfg.exit_smp == '0) ? SMP_W'(1) : cfg.exit_smp;

   assign enter_hit = CMP_W'(enter_inc) >= CMP_W'(enter_smp_eff);
   assign exit_hit  = CMP_W'(exit_inc) >= CMP_W'(exit_smp_eff);

   assign exit_thr_eff = (cfg.exit_thr > cfg.enter_thr) ? cfg.enter_thr : cfg.exit_thr;

   always_comb begin
      near_flag_in = near_flag_ff;
      enter_run_in = enter_run_ff;
      exit_run_in  = exit_run_ff;
      tr           = TR_NONE;
      if (cfg.enter_thr == '0) begin
         near_flag_in = 1'b0;
         enter_run_in = '0;
         exit_run_in  = '0;
      end else if (!near_flag_ff) begin
         exit_run_in = '0;
         if (reading < cfg.enter_thr) begin
            enter_run_in = '0;
         end else begin
            enter_run_in = enter_inc;
            if (enter_hit) begin
               near_flag_in = 1'b1;
               enter_run_in = '0;
               tr           = TR_APPROACHED;
            end
         end
      end else begin
         enter_run_in = '0;
         if (reading > exit_thr_eff) begin
            exit_run_in = '0;
         end else begin
            exit_run_in = exit_inc;
            if (exit_hit) begin
               near_flag_in = 1'b0;
               exit_run_in  = '0;
               tr           = TR_DEPARTED;
            end
         end
      end
   end

   always_comb begin
      res.tr   = tr;
      res.near = near_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_flag_ff <= 1'b0;
         enter_run_ff <= '0;
         exit_run_ff  <= '0;
      end else if (fire) begin
         near_flag_ff <= near_flag_in;
         enter_run_ff <= enter_run_in;
         exit_run_ff  <= exit_run_in;
      end
   end

`ifndef SYNTHESIS
   // only the run of the current direction may be live
   a_idle_run_clear: assert property (@(posedge clock) disable iff (reset)
      (near_flag_ff ? (enter_run_ff == '0) : (exit_run_ff == '0)))
      else $error("ppd_filter: run of unused direction not clear");

   a_approach_sets_near: assert property (@(posedge clock) disable iff (reset)
      (fire && (tr == TR_APPROACHED)) |=> near_flag_ff)
      else $error("ppd_filter: approach without near flag");

   a_depart_clears_near: assert property (@(posedge clock) disable iff (reset)
      (fire && (tr == TR_DEPARTED)) |=> !near_flag_ff)
      else $error("ppd_filter: departure left near flag set");

   a_disabled_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && (cfg.enter_thr == '0)) |=>
         (!near_flag_ff && (enter_run_ff == '0) && (exit_run_ff == '0)))
      else $error("ppd_filter: disabled filter kept state");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(near_flag_ff) && $stable(enter_run_ff) && $stable(exit_run_ff)))
      else $error("ppd_filter: state moved without a transaction");
`endif

endmodule

`default_nettype wire

// ===== hdl/proximity_presence_debouncer.sv =====
`default_nettype none

// Proximity presence debouncer. Each req_ transaction carries one 11-bit
// proximity reading and yields exactly one rsp_ transaction with the
// transition code (none, approached, departed) and the presence flag after
// that reading. Far to near needs enter_samples consecutive readings at or
// above enter_threshold; near to far needs exit_samples consecutive readings
// at or below exit_threshold (clamped to enter_threshold). A sample count of
// zero acts as one. An enter_threshold of zero disables the filter and clears
// its state. Run counters saturate at RUN_MAX; a sample count above RUN_MAX
// never fires. Throughput is one transaction per clock while rsp_stall is
// low; a reading passes the input register, then the filter update and the
// result register. req_stall follows rsp_stall combinationally only when
// both registers are full. Registers are written through the csr_ port
// while the block is idle (the user's duty; the block leaves it unenforced);
// they take effect on the next reading and leave the filter state alone.
module proximity_presence_debouncer #(
   parameter int RUN_MAX = 255
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ppd_pkg::READING_W-1:0]   req_proximity_reading,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_transition,
   output logic                                 rsp_is_near,
   // register write port
   input  wire logic                            csr_wen,
   input  wire logic [ppd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ppd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ppd_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   // input stage
   logic                 in_valid_ff, in_valid_in;
   logic [READING_W-1:0] reading_ff;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] transition_ff;
   logic       is_near_ff;

   logic    req_accept;
   logic    out_free;
   logic    advance;
   res_type res;

   // result register can take a new item when empty or being drained
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_thr <= ENTER_THR_RST;
         cfg_ff.exit_thr  <= EXIT_THR_RST;
         cfg_ff.enter_smp <= ENTER_SMP_RST;
         cfg_ff.exit_smp  <= EXIT_SMP_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ENTER_THR: cfg_ff.enter_thr <= csr_wdata[THR_W-1:0];
            CSR_EXIT_THR:  cfg_ff.exit_thr  <= csr_wdata[THR_W-1:0];
            CSR_ENTER_SMP: cfg_ff.enter_smp <= csr_wdata[SMP_W-1:0];
            CSR_EXIT_SMP:  cfg_ff.exit_smp  <= csr_wdata[SMP_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         reading_ff <= req_proximity_reading;
      end
      if (advance) begin
         transition_ff <= res.tr;
         is_near_ff    <= res.near;
      end
   end

   // filter state advances as the transaction moves into the result register
   ppd_filter #(
      .RUN_MAX (RUN_MAX)
   ) u_filter (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .reading (reading_ff),
      .cfg     (cfg_ff),
      .res     (res)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_transition = transition_ff;
   assign rsp_is_near    = is_near_ff;

endmodule

`default_nettype wire

// ===== tb/tb_proximity_presence_debouncer.sv =====
`default_nettype none

// Self-checking bench for the proximity presence debouncer.
// A short table of directed transactions comes first, then runs of readings
// grouped around the thresholds under a series of register settings. Every
// accepted reading is fed to a local copy of the filter and its result is
// queued; each rsp_ transaction is checked against the head of that queue.
module tb_proximity_presence_debouncer;
   import ppd_pkg::*;

   localparam int RUN_LIMIT = 255;
   localparam int N_SETS    = 15;

   typedef enum logic {
      ROW_ITEM,
      ROW_CFG
   } row_kind_type;

   // one line of the directed table; tr/near only used when pinned is set
   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   value;
      logic                    pinned;
      tr_type                  tr;
      logic                    near;
   } dir_row_type;

   // DUT connections
   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [READING_W-1:0]    req_proximity_reading;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [1:0]              rsp_transition;
   logic                    rsp_is_near;
   logic                    csr_wen;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // local copy of the filter: registers and state
   cfg_type                 cfg_shadow;
   logic                    near_st;
   logic [SMP_W-1:0]        enter_run_st;
   logic [SMP_W-1:0]        exit_run_st;

   // expected results, oldest first
   res_type                 expected_q[$];

   // expectation typed into the directed table, travels with the reading
   logic                    pin_en;
   res_type                 pin_res;

   int                      send_idle_pct;
   int                      stall_pct;
   int                      fail_count;
   int                      readings_sent;
   int                      approach_seen;
   int                      depart_seen;
   int                      settings_used;

   dir_row_type             dir_rows [25];

   proximity_presence_debouncer #(
      .RUN_MAX (RUN_LIMIT)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_proximity_reading (req_proximity_reading),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_transition        (rsp_transition),
      .rsp_is_near           (rsp_is_near),
      .csr_wen               (csr_wen),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < stall_pct);
   end

   // Effective exit threshold: never above the enter threshold.
   function automatic logic [THR_W-1:0] exit_limit();
      return (cfg_shadow.exit_thr > cfg_shadow.enter_thr) ? cfg_shadow.enter_thr
                                                          : cfg_shadow.exit_thr;
   endfunction

   // Advance the local filter by one reading and return its result.
   function automatic res_type step_debouncer(logic [READING_W-1:0] reading);
      res_type          r;
      logic [SMP_W-1:0] need;
      r.tr = TR_NONE;
      if (cfg_shadow.enter_thr == '0) begin
         // disabled: everything cleared, nothing reported
         near_st      = 1'b0;
         enter_run_st = '0;
         exit_run_st  = '0;
      end else if (!near_st) begin
         exit_run_st = '0;
         if (reading < cfg_shadow.enter_thr) begin
            enter_run_st = '0;
         end else begin
            if (enter_run_st < RUN_LIMIT) enter_run_st = enter_run_st + 1'b1;
            need = (cfg_shadow.enter_smp == '0) ? 8'd1 : cfg_shadow.enter_smp;
            if (enter_run_st >= need) begin
               near_st      = 1'b1;
               enter_run_st = '0;
               r.tr         = TR_APPROACHED;
            end
         end
      end else begin
         enter_run_st = '0;
         if (reading > exit_limit()) begin
            exit_run_st = '0;
         end else begin
            if (exit_run_st < RUN_LIMIT) exit_run_st = exit_run_st + 1'b1;
            need = (cfg_shadow.exit_smp == '0) ? 8'd1 : cfg_shadow.exit_smp;
            if (exit_run_st >= need) begin
               near_st     = 1'b0;
               exit_run_st = '0;
               r.tr        = TR_DEPARTED;
            end
         end
      end
      r.near = near_st;
      return r;
   endfunction

   // Accept side predicts, result side checks. Both sampled at the rising edge.
   always @(posedge clock) begin
      res_type exp_res;
      res_type got;
      if (!reset && req_valid && !req_stall) begin
         exp_res = step_debouncer(req_proximity_reading);
         if (pin_en) exp_res = pin_res;
         expected_q.push_back(exp_res);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_transition == TR_APPROACHED) approach_seen++;
         if (rsp_transition == TR_DEPARTED) depart_seen++;
         if (expected_q.size() == 0) begin
            $error("unexpected rsp transaction: transition %0d is_near %0d",
                   rsp_transition, rsp_is_near);
            fail_count++;
         end else begin
            got = expected_q.pop_front();
            if (rsp_transition !== got.tr) begin
               $error("transition: expected %0d, actual %0d", got.tr, rsp_transition);
               fail_count++;
            end
            if (rsp_is_near !== got.near) begin
               $error("is_near: expected %0d, actual %0d", got.near, rsp_is_near);
               fail_count++;
            end
         end
      end
   end

   // Sender holds off until every queued result has come back.
   task automatic drain();
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write; only called once the block has drained.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_ENTER_THR: cfg_shadow.enter_thr = val[THR_W-1:0];
         CSR_EXIT_THR:  cfg_shadow.exit_thr  = val[THR_W-1:0];
         CSR_ENTER_SMP: cfg_shadow.enter_smp = val[SMP_W-1:0];
         CSR_EXIT_SMP:  cfg_shadow.exit_smp  = val[SMP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // One req transaction; valid is left high so back-to-back readings
   // need no extra assignment.
   task automatic send_reading(logic [READING_W-1:0] reading, logic pinned, res_type pres);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_proximity_reading = reading;
      pin_en                = pinned;
      pin_res               = pres;
      do @(posedge clock); while (req_stall);
      readings_sent++;
      @(negedge clock);
   endtask

   // A run of readings that mostly qualifies for one direction, sized
   // around the sample count so that runs both complete and fall short.
   task automatic send_run(output int sent);
      int               mode;
      int               len;
      logic [SMP_W-1:0] need;
      logic [READING_W-1:0] rd;
      res_type          dummy;
      dummy = '0;
      mode  = $urandom_range(0, 9);
      need  = near_st ? cfg_shadow.exit_smp : cfg_shadow.enter_smp;
      if (need == '0) need = 8'd1;
      len   = (mode >= 8) ? 1 : $urandom_range(1, need + 2);
      for (int i = 0; i < len; i++) begin
         case (mode)
            0, 1, 2, 3: rd = READING_W'($urandom_range(2047, cfg_shadow.enter_thr));
            4, 5, 6, 7: rd = READING_W'($urandom_range(exit_limit(), 0));
            8: begin
               case ($urandom_range(0, 5))
                  0: rd = cfg_shadow.enter_thr;
                  1: rd = cfg_shadow.enter_thr - 1'b1;
                  2: rd = exit_limit();
                  3: rd = exit_limit() + 1'b1;
                  4: rd = '0;
                  default: rd = '1;
               endcase
            end
            default: rd = READING_W'($urandom_range(0, 2047));
         endcase
         send_reading(rd, 1'b0, dummy);
      end
      sent = len;
   endtask

   initial begin
      int       quota;
      int       done;
      int       n;
      logic     pressed;
      res_type  pres;

      // every input known from time zero
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_proximity_reading = '0;
      rsp_stall             = 1'b0;
      csr_wen               = 1'b0;
      csr_index             = CSR_ENTER_THR;
      csr_wdata             = '0;
      pin_en                = 1'b0;
      pin_res               = '0;
      send_idle_pct         = 0;
      stall_pct             = 0;
      fail_count            = 0;
      readings_sent         = 0;
      approach_seen         = 0;
      depart_seen           = 0;
      settings_used         = 0;

      cfg_shadow.enter_thr = ENTER_THR_RST;
      cfg_shadow.exit_thr  = EXIT_THR_RST;
      cfg_shadow.enter_smp = ENTER_SMP_RST;
      cfg_shadow.exit_smp  = EXIT_SMP_RST;
      near_st      = 1'b0;
      enter_run_st = '0;
      exit_run_st  = '0;

      // Directed table. Pinned rows carry results that follow directly from
      // the register values; the rest go through the predictor.
      dir_rows = '{
         // straight after reset the enter threshold is zero: filter disabled
         '{ROW_ITEM, CSR_ENTER_THR, 11'd2047, 1'b1, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd0,    1'b1, TR_NONE,       1'b0},
         '{ROW_CFG,  CSR_ENTER_THR, 11'd100,  1'b0, TR_NONE,       1'b0},
         '{ROW_CFG,  CSR_EXIT_THR,  11'd50,   1'b0, TR_NONE,       1'b0},
         // sample counts of one: single readings at the thresholds switch
         '{ROW_ITEM, CSR_ENTER_THR, 11'd99,   1'b1, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd100,  1'b1, TR_APPROACHED, 1'b1},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd51,   1'b1, TR_NONE,       1'b1},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd50,   1'b1, TR_DEPARTED,   1'b0},
         // zero sample count behaves as one
         '{ROW_CFG,  CSR_ENTER_SMP, 11'd0,    1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd2047, 1'b1, TR_APPROACHED, 1'b1},
         // run of three to leave, broken once part way
         '{ROW_CFG,  CSR_EXIT_SMP,  11'd3,    1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd0,    1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd0,    1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd2047, 1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd0,    1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd0,    1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd0,    1'b0, TR_NONE,       1'b0},
         // exit threshold above enter threshold is clamped;
         // sample write with high bits set keeps only the low byte
         '{ROW_CFG,  CSR_EXIT_THR,  11'd2047, 1'b0, TR_NONE,       1'b0},
         '{ROW_CFG,  CSR_ENTER_SMP, 11'h702,  1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd2047, 1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd2047, 1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd100,  1'b0, TR_NONE,       1'b0},
         // disabling clears the near state at once
         '{ROW_CFG,  CSR_ENTER_THR, 11'd0,    1'b0, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd0,    1'b1, TR_NONE,       1'b0},
         '{ROW_ITEM, CSR_ENTER_THR, 11'd2047, 1'b1, TR_NONE,       1'b0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            drain();
            write_reg(dir_rows[i].idx, dir_rows[i].value);
         end else begin
            pres.tr   = dir_rows[i].tr;
            pres.near = dir_rows[i].near;
            send_reading(dir_rows[i].value, dir_rows[i].pinned, pres);
         end
      end
      pin_en = 1'b0;

      // Random part: one register setting per set, idling pattern rotates
      // through none / sender / receiver / both.
      for (int s = 0; s < N_SETS; s++) begin
         drain();
         case (s)
            0: begin
               // top of both thresholds, zero sample counts
               write_reg(CSR_ENTER_THR, 11'd2047);
               write_reg(CSR_EXIT_THR,  11'd2047);
               write_reg(CSR_ENTER_SMP, 11'd0);
               write_reg(CSR_EXIT_SMP,  11'h700);
            end
            1: begin
               // lowest enabled threshold, exit at zero
               write_reg(CSR_ENTER_THR, 11'd1);
               write_reg(CSR_EXIT_THR,  11'd0);
               write_reg(CSR_ENTER_SMP, 11'd1);
               write_reg(CSR_EXIT_SMP,  11'd1);
            end
            2: begin
               // disabled, whatever else is set
               write_reg(CSR_ENTER_THR, 11'd0);
               write_reg(CSR_EXIT_THR,  11'($urandom_range(0, 2047)));
               write_reg(CSR_ENTER_SMP, 11'($urandom_range(0, 6)));
               write_reg(CSR_EXIT_SMP,  11'($urandom_range(0, 6)));
            end
            3: begin
               // longest runs, both sample counts at their top value of 255
               write_reg(CSR_ENTER_THR, 11'($urandom_range(1, 2047)));
               write_reg(CSR_EXIT_THR,  11'($urandom_range(0, 2047)));
               write_reg(CSR_ENTER_SMP, 11'h7FF);
               write_reg(CSR_EXIT_SMP,  11'd255);
            end
            default: begin
               write_reg(CSR_ENTER_THR, 11'($urandom_range(1, 2047)));
               write_reg(CSR_EXIT_THR,  11'($urandom_range(0, 2047)));
               write_reg(CSR_ENTER_SMP,
                         {3'($urandom_range(0, 7)), 8'($urandom_range(0, 6))});
               write_reg(CSR_EXIT_SMP,
                         {3'($urandom_range(0, 7)), 8'($urandom_range(0, 6))});
            end
         endcase
         settings_used++;

         case (s % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase

         quota   = (s == 3) ? 400 : 95;
         done    = 0;
         pressed = 1'b0;
         while (done < quota) begin
            send_run(n);
            done += n;
            // mid-set hold-off until the result queue is empty
            if (!pressed && done >= quota / 2 && (s % 2 == 0)) begin
               drain();
               pressed = 1'b1;
            end
         end
      end

      req_valid     = 1'b0;
      send_idle_pct = 0;
      while (expected_q.size() != 0) @(negedge clock);
      stall_pct = 0;
      repeat (10) @(negedge clock);

      $display("Ran %0d readings over %0d random register settings plus the directed table;",
               readings_sent, settings_used);
      $display("observed %0d approaches and %0d departures.", approach_seen, depart_seen);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
